/* sv/dasch_pkg.sv */
// Shared types, constants and codes of the disk arm scheduler.
package dasch_pkg;

  localparam int CYL_W           = 16;
  localparam int DIST_W          = 21;
  localparam int ALG_W           = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int MAX_REQUESTS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [ALG_W-1:0] ALG_FCFS  = 3'd0;
  localparam logic [ALG_W-1:0] ALG_SSTF  = 3'd1;
  localparam logic [ALG_W-1:0] ALG_SCAN  = 3'd2;
  localparam logic [ALG_W-1:0] ALG_CSCAN = 3'd3;
  localparam logic [ALG_W-1:0] ALG_LOOK  = 3'd4;
  localparam logic [ALG_W-1:0] ALG_CLOOK = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CYLINDER = 2'd2;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [CYL_W-1:0]  position;
    logic              is_marker;
    logic [DIST_W-1:0] total_distance;
    logic              overflow;
    logic              last_res;
  } result_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             write;
    logic             last;
    logic             dropped;
  } entry_t;

endpackage

/* sv/dasch_front.sv */
// Front end: accepts requests, counts store slots and classifies store/drop/last.
module dasch_front import dasch_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  item_t  item,
  input  logic   queue_full,
  output logic   busy,
  output logic   push,
  output entry_t entry
);

  localparam int CNTW = $clog2(MAX_REQUESTS + 1);

  logic [CNTW-1:0] count;
  logic            dropped;
  logic            accept;
  logic            room;

  assign busy   = queue_full;
  assign accept = start && !queue_full;
  assign room   = count < CNTW'(MAX_REQUESTS);

  assign entry.cylinder = item.cylinder;
  assign entry.write    = room;
  assign entry.last     = item.last;
  assign entry.dropped  = dropped || !room;
  assign push           = accept && (room || item.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (item.last) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (room) begin
        count <= count + 1'b1;
      end else begin
        dropped <= 1'b1;
      end
    end
  end

endmodule

/* sv/dasch_queue.sv */
// Short queue of classified requests between front and back.
module dasch_queue import dasch_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign empty = fill == '0;
  assign full  = fill == (PW+1)'(QUEUE_DEPTH);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

/* sv/dasch_back.sv */
// Back end: request store and the selection engine that emits the service order.
module dasch_back import dasch_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  entry_t           head,
  input  logic             empty,
  output logic             pop,
  input  logic [ALG_W-1:0] algorithm,
  input  logic [CYL_W-1:0] start_head,
  input  logic [CYL_W-1:0] max_cylinder,
  output logic             result_valid,
  output result_t          result
);

  localparam int CNTW = $clog2(MAX_REQUESTS + 1);
  localparam int IDXW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_PICK    = 5'b00100,
    S_MARK_HI = 5'b01000,
    S_MARK_LO = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CYL_W-1:0]        mem [MAX_REQUESTS];
  logic [CYL_W-1:0]        rd_data;
  logic [CNTW-1:0]         wr_ptr;
  logic [CNTW-1:0]         n;
  logic [CNTW-1:0]         rd_cnt;
  logic [CNTW-1:0]         emitted;
  logic [IDXW-1:0]         cmp_idx;
  logic                    cmp_valid;
  logic [MAX_REQUESTS-1:0] served;
  logic [ALG_W-1:0]        alg;
  logic                    down;
  logic                    dropped;
  logic [CYL_W-1:0]        arm;
  logic [DIST_W-1:0]       travel;

  logic                    best_valid;
  logic [CYL_W-1:0]        best_key;
  logic [CYL_W-1:0]        best_val;
  logic [IDXW-1:0]         best_idx;

  logic                    is_sstf;
  logic                    is_sweep;
  logic                    rev_down;
  logic [CYL_W-1:0]        gap;
  logic [CYL_W-1:0]        key;
  logic                    eligible;
  logic                    better;

  logic                    emit;
  logic [CYL_W-1:0]        emit_pos;
  logic                    emit_marker;
  logic                    emit_last;
  logic [CYL_W-1:0]        step;
  logic [DIST_W:0]         sum;
  logic [DIST_W-1:0]       travel_next;
  logic                    scan_start;
  logic                    final_req;

  assign is_sstf  = alg == ALG_SSTF;
  assign is_sweep = (alg == ALG_SCAN) || (alg == ALG_CSCAN) ||
                    (alg == ALG_LOOK) || (alg == ALG_CLOOK);
  assign rev_down = (alg == ALG_SCAN) || (alg == ALG_LOOK);

  assign pop = (state == S_IDLE) && !empty;

  // Store write on pop, registered read during a scan.
  always_ff @(posedge clk) begin
    if (pop && head.write) begin
      mem[wr_ptr[IDXW-1:0]] <= head.cylinder;
    end
    if (state == S_SCAN && rd_cnt < n) begin
      rd_data <= mem[rd_cnt[IDXW-1:0]];
    end
  end

  // Selection key of the entry under compare.
  always_comb begin
    gap = (rd_data > arm) ? rd_data - arm : arm - rd_data;
    if (is_sstf) begin
      key = gap;
    end else if (is_sweep && !down) begin
      key = rd_data;
    end else if (is_sweep && rev_down) begin
      key = ~rd_data;
    end else if (is_sweep) begin
      key = rd_data;
    end else begin
      key = '0;
    end
    eligible = !served[cmp_idx] && (!(is_sweep && !down) || rd_data >= start_head);
    better   = cmp_valid && eligible && (!best_valid || key < best_key);
  end

  assign final_req = CNTW'(emitted + 1'b1) == n;

  // Emit control and next state.
  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_pos    = best_val;
    emit_marker = 1'b0;
    emit_last   = 1'b0;
    scan_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pop && head.last) begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_valid && cmp_idx == IDXW'(n - 1'b1)) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (best_valid) begin
          emit      = 1'b1;
          emit_last = final_req;
          if (final_req) begin
            state_next = S_IDLE;
          end else begin
            scan_start = 1'b1;
            state_next = S_SCAN;
          end
        end else if (is_sweep && !down) begin
          if (alg == ALG_SCAN || alg == ALG_CSCAN) begin
            state_next = S_MARK_HI;
          end else begin
            scan_start = 1'b1;
            state_next = S_SCAN;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MARK_HI: begin
        emit        = 1'b1;
        emit_pos    = max_cylinder;
        emit_marker = 1'b1;
        if (alg == ALG_CSCAN) begin
          state_next = S_MARK_LO;
        end else begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_MARK_LO: begin
        emit        = 1'b1;
        emit_pos    = '0;
        emit_marker = 1'b1;
        scan_start  = 1'b1;
        state_next  = S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign step = (emit_pos > arm) ? emit_pos - arm : arm - emit_pos;
  assign sum  = {1'b0, travel} + (DIST_W+1)'(step);
  assign travel_next = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wr_ptr       <= '0;
      n            <= '0;
      rd_cnt       <= '0;
      emitted      <= '0;
      cmp_valid    <= 1'b0;
      served       <= '0;
      down         <= 1'b0;
      dropped      <= 1'b0;
      best_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (pop) begin
        if (head.last) begin
          wr_ptr  <= '0;
          n       <= head.write ? CNTW'(wr_ptr + 1'b1) : wr_ptr;
          alg     <= algorithm;
          dropped <= head.dropped;
          arm     <= start_head;
          travel  <= '0;
          served  <= '0;
          emitted <= '0;
          down    <= 1'b0;
        end else if (head.write) begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      // Advance the scan: issue a read, compare the previous one.
      if (state == S_SCAN) begin
        if (rd_cnt < n) begin
          cmp_idx   <= rd_cnt[IDXW-1:0];
          cmp_valid <= 1'b1;
          rd_cnt    <= rd_cnt + 1'b1;
        end else begin
          cmp_valid <= 1'b0;
        end
        if (better) begin
          best_valid <= 1'b1;
          best_key   <= key;
          best_val   <= rd_data;
          best_idx   <= cmp_idx;
        end
      end
      if (state == S_PICK) begin
        if (best_valid) begin
          served[best_idx] <= 1'b1;
          emitted          <= emitted + 1'b1;
        end else begin
          down <= 1'b1;
        end
      end
      if (scan_start) begin
        rd_cnt     <= '0;
        cmp_valid  <= 1'b0;
        best_valid <= 1'b0;
      end
      if (emit) begin
        arm    <= emit_pos;
        travel <= travel_next;
        result.position       <= emit_pos;
        result.is_marker      <= emit_marker;
        result.total_distance <= emit_last ? travel_next : '0;
        result.overflow       <= dropped;
        result.last_res       <= emit_last;
      end
    end
  end

endmodule

/* sv/disk_arm_scheduler_core.sv */
// Top level of the disk arm scheduler: config registers, front, queue and back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------
//  request  | start / busy            | item   (cylinder, last)
//  result   | result_valid (strobe)   | result (position, is_marker,
//           |                         |         total_distance, overflow,
//           |                         |         last_res)
//  config   | cfg_we                  | cfg_index, cfg_data
//
// A request beat is taken whenever busy is low; busy rises only while the
// two-entry queue to the back end is full. Once the beat marked last reaches
// the back end, each emitted position costs one selection scan over the store
// through the single read port of the request store; the result strobe is
// registered and follows in the cycle after the pick. A sweep that turns spends
// one empty scan first; end markers are emitted from S_MARK_HI and S_MARK_LO.
// Reset is synchronous, clears control state and sets the config registers to their defaults.
// Results are strobed for one cycle and the receiver cannot stall them.
module disk_arm_scheduler_core import dasch_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  item_t                 item,
  output logic                  busy,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  output result_t               result
);

  logic [ALG_W-1:0] algorithm;
  logic [CYL_W-1:0] start_head;
  logic [CYL_W-1:0] max_cylinder;

  logic   push;
  entry_t push_entry;
  entry_t queue_head;
  logic   queue_empty;
  logic   queue_full;
  logic   pop;

  // Config registers; writes to unused indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm    <= ALG_FCFS;
      start_head   <= CYL_W'(50);
      max_cylinder <= CYL_W'(199);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALGORITHM:    algorithm    <= cfg_data[ALG_W-1:0];
        CFG_START_HEAD:   start_head   <= cfg_data[CYL_W-1:0];
        CFG_MAX_CYLINDER: max_cylinder <= cfg_data[CYL_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify each request beat: store, drop, or close the batch.
  dasch_front #(.MAX_REQUESTS(MAX_REQUESTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .entry      (push_entry)
  );

  // Hold classified beats while the back end is scheduling.
  dasch_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (queue_head),
    .empty      (queue_empty),
    .full       (queue_full)
  );

  // Store requests and emit the service order.
  dasch_back #(.MAX_REQUESTS(MAX_REQUESTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (queue_head),
    .empty        (queue_empty),
    .pop          (pop),
    .algorithm    (algorithm),
    .start_head   (start_head),
    .max_cylinder (max_cylinder),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* test/testbench.sv */
// Testbench for disk_arm_scheduler_core: directed and random request batches.
module testbench;
  import dasch_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes outside the package: spare algorithm codes and the unused register index.
  localparam logic [ALG_W-1:0]     ALG_SPARE6 = 3'd6;
  localparam logic [ALG_W-1:0]     ALG_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int NREQ       = 16;
  localparam int SETTLE     = 60;    // cycles for the back end to go quiet
  localparam int STALL_MAX  = 4000;  // cycles without any beat before giving up
  localparam int RAND_ITEMS = 75;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  item_t                 item = '0;
  logic                  busy;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_valid;
  result_t               result;

  disk_arm_scheduler_core u_dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  always #4 clk = ~clk;

  // Shadow of the scheduler's registers and batch store.
  logic [ALG_W-1:0]  sched_alg;
  logic [CYL_W-1:0]  sched_head;
  logic [CYL_W-1:0]  sched_maxcyl;
  logic [CYL_W-1:0]  pending_cyl [NREQ];
  int                pending_n;
  logic              pending_dropped;
  logic [CYL_W-1:0]  arm_at;
  logic [DIST_W-1:0] arm_travel;

  result_t visit_q [$];     // service order of the batch just closed
  result_t service_q [$];   // positions still owed by the block
  int      err_count;
  int      quiet_cycles;
  bit      calm;            // no sender gaps while set

  // Move the arm to pos, summing travel with saturation.
  function automatic void visit(logic [CYL_W-1:0] pos, logic mark);
    result_t r;
    int unsigned sum;
    sum = int'(arm_travel) + (pos > arm_at ? int'(pos - arm_at) : int'(arm_at - pos));
    arm_travel = (sum > int'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    arm_at = pos;
    r = '0;
    r.position  = pos;
    r.is_marker = mark;
    r.overflow  = pending_dropped;
    visit_q.push_back(r);
  endfunction

  // Store one request; on the closing beat, schedule the batch into visit_q.
  function automatic void schedule_beat(item_t it);
    logic [CYL_W-1:0] srt [NREQ];
    logic [CYL_W-1:0] v;
    bit served [NREQ];
    int below, best, j;
    int unsigned d, bestd;
    visit_q.delete();
    if (pending_n < NREQ) begin
      pending_cyl[pending_n] = it.cylinder;
      pending_n++;
    end else begin
      pending_dropped = 1'b1;
    end
    if (!it.last) return;
    arm_at = sched_head;
    arm_travel = '0;
    below = 0;
    case (sched_alg) inside
      ALG_SSTF: begin
        for (int i = 0; i < NREQ; i++) served[i] = 1'b0;
        for (int i = 0; i < pending_n; i++) begin
          best = -1;
          bestd = 0;
          for (int k = 0; k < pending_n; k++) begin
            v = pending_cyl[k];
            d = v > arm_at ? v - arm_at : arm_at - v;
            if (!served[k] && (best < 0 || d < bestd)) begin
              best = k;
              bestd = d;
            end
          end
          served[best] = 1'b1;
          visit(pending_cyl[best], 1'b0);
        end
      end
      ALG_SCAN, ALG_CSCAN, ALG_LOOK, ALG_CLOOK: begin
        for (int i = 0; i < pending_n; i++) begin
          v = pending_cyl[i];
          j = i;
          while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1];
            j--;
          end
          srt[j] = v;
        end
        // Upward sweep first; requests at the head go here at zero cost.
        for (int i = 0; i < pending_n; i++)
          if (srt[i] >= sched_head) visit(srt[i], 1'b0);
          else below++;
        if (below > 0) begin
          if (sched_alg == ALG_SCAN || sched_alg == ALG_CSCAN) visit(sched_maxcyl, 1'b1);
          if (sched_alg == ALG_CSCAN) visit('0, 1'b1);
          if (sched_alg == ALG_SCAN || sched_alg == ALG_LOOK) begin
            for (int i = pending_n - 1; i >= 0; i--)
              if (srt[i] < sched_head) visit(srt[i], 1'b0);
          end else begin
            for (int i = 0; i < pending_n; i++)
              if (srt[i] < sched_head) visit(srt[i], 1'b0);
          end
        end
      end
      default: begin
        // FCFS and the spare codes.
        for (int i = 0; i < pending_n; i++) visit(pending_cyl[i], 1'b0);
      end
    endcase
    if (visit_q.size() > 0) begin
      visit_q[visit_q.size()-1].total_distance = arm_travel;
      visit_q[visit_q.size()-1].last_res = 1'b1;
    end
    pending_n = 0;
    pending_dropped = 1'b0;
  endfunction

  // Drive a request beat and hold it until taken. Called just after posedge clk.
  task automatic send_beat(item_t it, bit typed, result_t want);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    schedule_beat(it);
    if (typed && it.last) service_q.push_back(want);
    else foreach (visit_q[i]) service_q.push_back(visit_q[i]);
    // Idle now and then; lower start only when a gap follows.
    if (!calm && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drain the block, let it settle, then write all registers.
  task automatic set_registers(logic [ALG_W-1:0] alg, logic [CYL_W-1:0] head,
                               logic [CYL_W-1:0] maxc, bit poke_unused);
    start <= 1'b0;
    wait (service_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ALGORITHM;
    cfg_data <= CFG_DATA_W'(alg);
    @(posedge clk);
    cfg_index <= CFG_START_HEAD;
    cfg_data <= head;
    @(posedge clk);
    cfg_index <= CFG_MAX_CYLINDER;
    cfg_data <= maxc;
    @(posedge clk);
    if (poke_unused) begin
      // Index 3 holds nothing; the block must ignore it.
      cfg_index <= CFG_UNUSED;
      cfg_data <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sched_alg = alg;
    sched_head = head;
    sched_maxcyl = maxc;
  endtask

  // Pick a cylinder: extremes, the head itself, near the head, or anywhere.
  function automatic logic [CYL_W-1:0] pick_cyl();
    int unsigned sel;
    int off;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel <= 3) return sched_head;
    if (sel <= 10) begin
      off = int'(sched_head) + $urandom_range(0, 600) - 300;
      if (off < 0) off = 0;
      if (off > 65535) off = 65535;
      return off[CYL_W-1:0];
    end
    return CYL_W'($urandom);
  endfunction

  function automatic logic [CYL_W-1:0] pick_reg16();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return CYL_W'($urandom_range(0, 400));
      default: return CYL_W'($urandom);
    endcase
  endfunction

  // Check each strobed position against the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (service_q.size() == 0) begin
        $error("unexpected result beat: position %0d", result.position);
        err_count++;
      end else begin
        want = service_q.pop_front();
        if (result.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, result.position);
          err_count++;
        end
        if (result.is_marker !== want.is_marker) begin
          $error("is_marker: expected %0b, got %0b", want.is_marker, result.is_marker);
          err_count++;
        end
        if (result.total_distance !== want.total_distance) begin
          $error("total_distance: expected %0d, got %0d",
                 want.total_distance, result.total_distance);
          err_count++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
          err_count++;
        end
        if (result.last_res !== want.last_res) begin
          $error("last_res: expected %0b, got %0b", want.last_res, result.last_res);
          err_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Directed table: a register write opens a new setting; typed results only
  // where they are plain (reset setting, extreme travel).
  typedef struct {
    bit               wr;
    logic [ALG_W-1:0] alg;
    logic [CYL_W-1:0] head;
    logic [CYL_W-1:0] maxc;
    logic [CYL_W-1:0] cyl;
    logic             last;
    bit               typed;
    result_t          want;
  } row_t;

  localparam int NROWS = 23;
  row_t plan [NROWS];

  initial begin
    item_t it;
    int n_items, batch;
    quiet_cycles = 0;
    err_count = 0;
    calm = 1'b0;
    sched_alg = ALG_FCFS;
    sched_head = 16'd50;
    sched_maxcyl = 16'd199;
    pending_n = 0;
    pending_dropped = 1'b0;
    arm_at = '0;
    arm_travel = '0;

    // After reset: FCFS from 50, one request at 60.
    plan[0]  = '{0, ALG_FCFS, 0, 0, 16'd60, 1, 1, '{16'd60, 1'b0, 21'd10, 1'b0, 1'b1}};
    // SSTF with a request at the head and a tie (90 and 110 from 100).
    plan[1]  = '{1, ALG_SSTF, 16'd100, 16'd199, 16'd100, 0, 0, '0};
    plan[2]  = '{0, ALG_SSTF, 0, 0, 16'd90, 0, 0, '0};
    plan[3]  = '{0, ALG_SSTF, 0, 0, 16'd110, 0, 0, '0};
    plan[4]  = '{0, ALG_SSTF, 0, 0, 16'd120, 1, 0, '0};
    // SCAN with requests both sides and one at the head.
    plan[5]  = '{1, ALG_SCAN, 16'd100, 16'd199, 16'd150, 0, 0, '0};
    plan[6]  = '{0, ALG_SCAN, 0, 0, 16'd30, 0, 0, '0};
    plan[7]  = '{0, ALG_SCAN, 0, 0, 16'd100, 0, 0, '0};
    plan[8]  = '{0, ALG_SCAN, 0, 0, 16'd180, 1, 0, '0};
    // C-SCAN with both markers.
    plan[9]  = '{1, ALG_CSCAN, 16'd100, 16'd199, 16'd40, 0, 0, '0};
    plan[10] = '{0, ALG_CSCAN, 0, 0, 16'd160, 0, 0, '0};
    plan[11] = '{0, ALG_CSCAN, 0, 0, 16'd20, 1, 0, '0};
    // SCAN with nothing below the head: no marker.
    plan[12] = '{1, ALG_SCAN, 16'd100, 16'd199, 16'd120, 0, 0, '0};
    plan[13] = '{0, ALG_SCAN, 0, 0, 16'd140, 1, 0, '0};
    // LOOK turning back.
    plan[14] = '{1, ALG_LOOK, 16'd100, 16'd199, 16'd120, 0, 0, '0};
    plan[15] = '{0, ALG_LOOK, 0, 0, 16'd70, 0, 0, '0};
    plan[16] = '{0, ALG_LOOK, 0, 0, 16'd90, 1, 0, '0};
    // C-LOOK wrapping to the lowest request.
    plan[17] = '{1, ALG_CLOOK, 16'd100, 16'd199, 16'd10, 0, 0, '0};
    plan[18] = '{0, ALG_CLOOK, 0, 0, 16'd200, 0, 0, '0};
    plan[19] = '{0, ALG_CLOOK, 0, 0, 16'd5, 1, 0, '0};
    // Spare code 6 acts as FCFS: full sweep from 0 to the top cylinder.
    plan[20] = '{1, ALG_SPARE6, 16'd0, 16'hFFFF, 16'hFFFF, 1, 1,
                 '{16'hFFFF, 1'b0, 21'd65535, 1'b0, 1'b1}};
    // Spare code 7, top head, requests at 0 and at the top cylinder.
    plan[21] = '{1, ALG_SPARE7, 16'hFFFF, 16'hFFFF, 16'd0, 0, 0, '0};
    plan[22] = '{0, ALG_SPARE7, 0, 0, 16'hFFFF, 1, 0, '0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].wr) set_registers(plan[r].alg, plan[r].head, plan[r].maxc, r == 21);
      it.cylinder = plan[r].cyl;
      it.last = plan[r].last;
      send_beat(it, plan[r].typed, plan[r].want);
    end

    // Random batches; occasional oversize ones overflow the store.
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      calm = (n_items >= 40 && n_items < 70);
      if ($urandom_range(0, 2) == 0)
        set_registers(ALG_W'($urandom_range(0, 7)), pick_reg16(), pick_reg16(),
                      $urandom_range(0, 3) == 0);
      batch = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
      for (int b = 0; b < batch; b++) begin
        it.cylinder = pick_cyl();
        it.last = (b == batch - 1);
        send_beat(it, 1'b0, '0);
        n_items++;
      end
    end
    start <= 1'b0;

    // Drain with a bound, then let the back end settle.
    fork
      wait (service_q.size() == 0);
      repeat (20000) @(posedge clk);
    join_any
    disable fork;
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && service_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
